// ===== hw/rtl/bilr_pkg.sv =====
`default_nettype none

package bilr_pkg;

  // Fixed field widths of the interface.
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 20;
  localparam int BYTE_W    = 8;
  localparam int RGB_W     = 24;
  localparam int DIDX_W    = 24;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 6;

  // Default sizes of the stores and the arithmetic.
  localparam int SOURCE_PIXELS_DEF = 1048576;
  localparam int ALPHA_PIXELS_DEF  = 262144;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_RGB   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_H = 3'd5;

  // Command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic valid;
    logic accum;
  } mac_cmd_t;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // A size of zero counts as one; sizes above the limit saturate.
  function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxd);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxd) begin
      r = DIM_W'(maxd);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bilinear_rgb_resampler.sv =====
// Bilinear RGB resampler with a separate alpha plane.
//
// Input channel (in_valid/in_ready): each transfer is a load of one source RGB
// pixel, a load of one alpha pixel, or a request for the next destination
// pixel; any other kind is ignored. Loads outside the configured image size
// are dropped. A request yields one ARGB pixel on the output channel
// (out_valid/out_ready) in raster order; out_last marks a frame's last pixel.
// Configuration channel (cfg_valid/cfg_ready) is always ready; a write sets
// one size register and restarts the destination frame.
// A request runs three divisions per axis on the shared serial divider of
// DW = max(27, 14 + FRACTION_BITS) bits (integer part, fraction, alpha
// coordinate); an axis whose numerator is negative skips the integer
// division. A request also makes five store reads, three channel blends
// and further multiply steps. The input is not ready while a load or a
// request is processed.
// A finished pixel sits in the output register; the next load is taken while
// it waits, and a further request stalls at its end until the register frees.
// Reset clears the size registers to one and the raster position to zero.
// Store contents are undefined after reset until written.
`default_nettype none

module bilinear_rgb_resampler import bilr_pkg::*; #(
  parameter int SOURCE_PIXELS = SOURCE_PIXELS_DEF,
  parameter int ALPHA_PIXELS  = ALPHA_PIXELS_DEF,
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [KIND_W-1:0]    in_kind,
  input  wire logic [PIX_W-1:0]     in_pixel_index,
  input  wire logic [BYTE_W-1:0]    in_red,
  input  wire logic [BYTE_W-1:0]    in_green,
  input  wire logic [BYTE_W-1:0]    in_blue,
  input  wire logic [BYTE_W-1:0]    in_alpha,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [BYTE_W-1:0]    out_alpha,
  output      logic [BYTE_W-1:0]    out_red,
  output      logic [BYTE_W-1:0]    out_green,
  output      logic [BYTE_W-1:0]    out_blue,
  output      logic [DIDX_W-1:0]    out_dest_index,
  output      logic                 out_last,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  localparam int F      = FRACTION_BITS;
  localparam int SRC_AW = $clog2(SOURCE_PIXELS);
  localparam int ALP_AW = $clog2(ALPHA_PIXELS);
  localparam int NUM_W  = 2 * DIM_W + 1;
  localparam int DEN_W  = DIM_W + 1;
  localparam int DVD_W  = (NUM_W > DEN_W + F) ? NUM_W : DEN_W + F;
  localparam int IDX_W  = 2 * DIM_W;
  localparam int MA_W   = (F + BYTE_W > DIM_W + 1) ? F + BYTE_W : DIM_W + 1;
  localparam int MB_W   = (F + 1 > DIM_W) ? F + 1 : DIM_W;
  localparam int ACC_W  = MA_W + MB_W + 1;

  localparam logic [IDX_W:0]   SRC_LIM = (IDX_W + 1)'(SOURCE_PIXELS);
  localparam logic [IDX_W:0]   ALP_LIM = (IDX_W + 1)'(ALPHA_PIXELS);
  localparam logic [F:0]       ONE     = {1'b1, {F{1'b0}}};
  localparam logic [ACC_W-1:0] ROUND   = ACC_W'(1) << (2 * F - 1);

  // Read slots: four source neighbors, then the alpha sample.
  localparam logic [2:0] RD_P00   = 3'd0;
  localparam logic [2:0] RD_P10   = 3'd1;
  localparam logic [2:0] RD_P01   = 3'd2;
  localparam logic [2:0] RD_P11   = 3'd3;
  localparam logic [2:0] RD_ALPHA = 3'd4;

  // Blend steps for one channel.
  localparam logic [2:0] BL_P00  = 3'd0;
  localparam logic [2:0] BL_P10  = 3'd1;
  localparam logic [2:0] BL_P01  = 3'd2;
  localparam logic [2:0] BL_P11  = 3'd3;
  localparam logic [2:0] BL_ROW0 = 3'd4;
  localparam logic [2:0] BL_ROW1 = 3'd5;
  localparam logic [2:0] BL_DONE = 3'd6;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_MUL,
    S_LOAD_WR,
    S_MAP_MUL,
    S_MAP_CHK,
    S_IDIV,
    S_FDIV,
    S_AMUL,
    S_ASTART,
    S_ADIV,
    S_RD_MUL,
    S_RD_ADDR,
    S_RD_DATA,
    S_BLEND,
    S_IDX_MUL,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic              ax_sel_r, ax_sel_nxt;
  logic [2:0]        rd_n_r, rd_n_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  regs_r [NUM_REGS];
  logic [DIM_W-1:0]  regs_nxt [NUM_REGS];
  logic              out_valid_r, out_valid_nxt;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [PIX_W-1:0]  pix_idx_r, pix_idx_nxt;
  logic [RGB_W-1:0]  rgb_in_r, rgb_in_nxt;
  logic [BYTE_W-1:0] alpha_in_r, alpha_in_nxt;
  logic              neg_r [2];
  logic              neg_nxt [2];
  logic [DIM_W-1:0]  iq_r [2];
  logic [DIM_W-1:0]  iq_nxt [2];
  logic [F-1:0]      frac_r [2];
  logic [F-1:0]      frac_nxt [2];
  logic [DIM_W-1:0]  acoord_r [2];
  logic [DIM_W-1:0]  acoord_nxt [2];
  logic [RGB_W-1:0]  pix_r [4];
  logic [RGB_W-1:0]  pix_nxt [4];
  logic [BYTE_W-1:0] alpha_r, alpha_nxt;
  logic              oob_r, oob_nxt;
  logic [MA_W-1:0]   h0_r, h0_nxt;
  logic [MA_W-1:0]   h1_r, h1_nxt;
  logic [BYTE_W-1:0] chan_r [3];
  logic [BYTE_W-1:0] chan_nxt [3];
  logic [BYTE_W-1:0] out_alpha_r, out_alpha_nxt;
  logic [BYTE_W-1:0] out_red_r, out_red_nxt;
  logic [BYTE_W-1:0] out_green_r, out_green_nxt;
  logic [BYTE_W-1:0] out_blue_r, out_blue_nxt;
  logic [DIDX_W-1:0] out_index_r, out_index_nxt;
  logic              out_last_r, out_last_nxt;

  // Effective sizes.
  logic [DIM_W-1:0]  sw, sh, dw, dh, aw, ah;
  // Per-axis selections.
  logic [DIM_W-1:0]  d_sel, src_sel, dst_sel, asz_sel;
  logic [DEN_W-1:0]  odd, den;
  logic [NUM_W-1:0]  prod, dst_ext;
  // Clamped neighbor coordinates.
  logic [DIM_W-1:0]  x0, x1, y0, y1;
  logic [DIM_W:0]    xi1, yi1;
  logic [DIM_W-1:0]  rd_x, rd_y, rd_w;
  logic [IDX_W-1:0]  idx;
  logic              src_inb, alp_inb, load_ok;
  logic [BYTE_W-1:0] byte_sel;
  logic [RGB_W-1:0]  blend_pix;
  logic [F:0]        fx_inv, fy_inv;

  // Shared units.
  mac_cmd_t          mac_cmd;
  logic [MA_W-1:0]   mac_a;
  logic [MB_W-1:0]   mac_b;
  logic [ACC_W-1:0]  mac_addend;
  logic [ACC_W-1:0]  mac_acc;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;

  // Stores.
  logic              src_we, src_re, alp_we, alp_re;
  logic [SRC_AW-1:0] src_addr;
  logic [ALP_AW-1:0] alp_addr;
  logic [RGB_W-1:0]  src_rdata;
  logic [BYTE_W-1:0] alp_rdata;

  bilr_mac #(
    .A_W   (MA_W),
    .B_W   (MB_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .cmd    (mac_cmd),
    .a      (mac_a),
    .b      (mac_b),
    .addend (mac_addend),
    .acc    (mac_acc)
  );

  bilr_div #(
    .DVD_W (DVD_W),
    .DVS_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (den),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  bilr_ram #(
    .WIDTH (RGB_W),
    .DEPTH (SOURCE_PIXELS)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .re    (src_re),
    .addr  (src_addr),
    .wdata (rgb_in_r),
    .rdata (src_rdata)
  );

  bilr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (ALPHA_PIXELS)
  ) u_alp_ram (
    .clk   (clk),
    .we    (alp_we),
    .re    (alp_re),
    .addr  (alp_addr),
    .wdata (alpha_in_r),
    .rdata (alp_rdata)
  );

  // Size registers as used by the datapath.
  always_comb begin
    sw = dim_limit(regs_r[REG_SRC_W], MAX_DIMENSION);
    sh = dim_limit(regs_r[REG_SRC_H], MAX_DIMENSION);
    dw = dim_limit(regs_r[REG_DST_W], MAX_DIMENSION);
    dh = dim_limit(regs_r[REG_DST_H], MAX_DIMENSION);
    aw = dim_limit(regs_r[REG_ALPHA_W], MAX_DIMENSION);
    ah = dim_limit(regs_r[REG_ALPHA_H], MAX_DIMENSION);
  end

  // Axis operands, neighbor clamps and store index checks.
  always_comb begin
    d_sel   = ax_sel_r ? row_r : col_r;
    src_sel = ax_sel_r ? sh : sw;
    dst_sel = ax_sel_r ? dh : dw;
    asz_sel = ax_sel_r ? ah : aw;
    odd     = {d_sel, 1'b1};
    den     = {dst_sel, 1'b0};
    prod    = mac_acc[NUM_W-1:0];
    dst_ext = NUM_W'(dst_sel);

    xi1 = {1'b0, iq_r[0]} + (DIM_W + 1)'(1);
    yi1 = {1'b0, iq_r[1]} + (DIM_W + 1)'(1);
    if (neg_r[0]) begin
      x0 = '0;
      x1 = '0;
    end else begin
      x0 = (iq_r[0] > sw - DIM_W'(1)) ? sw - DIM_W'(1) : iq_r[0];
      x1 = (xi1 > {1'b0, sw - DIM_W'(1)}) ? sw - DIM_W'(1) : xi1[DIM_W-1:0];
    end
    if (neg_r[1]) begin
      y0 = '0;
      y1 = '0;
    end else begin
      y0 = (iq_r[1] > sh - DIM_W'(1)) ? sh - DIM_W'(1) : iq_r[1];
      y1 = (yi1 > {1'b0, sh - DIM_W'(1)}) ? sh - DIM_W'(1) : yi1[DIM_W-1:0];
    end

    case (rd_n_r)
      RD_P00: begin
        rd_x = x0;
        rd_y = y0;
        rd_w = sw;
      end
      RD_P10: begin
        rd_x = x1;
        rd_y = y0;
        rd_w = sw;
      end
      RD_P01: begin
        rd_x = x0;
        rd_y = y1;
        rd_w = sw;
      end
      RD_P11: begin
        rd_x = x1;
        rd_y = y1;
        rd_w = sw;
      end
      default: begin
        rd_x = acoord_r[0];
        rd_y = acoord_r[1];
        rd_w = aw;
      end
    endcase

    idx     = mac_acc[IDX_W-1:0];
    src_inb = {1'b0, idx} < SRC_LIM;
    alp_inb = {1'b0, idx} < ALP_LIM;
    if (kind_r == KIND_RGB) begin
      load_ok = (IDX_W'(pix_idx_r) < idx) && ((IDX_W + 1)'(pix_idx_r) < SRC_LIM);
    end else begin
      load_ok = (IDX_W'(pix_idx_r) < idx) && ((IDX_W + 1)'(pix_idx_r) < ALP_LIM);
    end
  end

  // Channel byte of the neighbor that the current blend step uses.
  always_comb begin
    case (st_r)
      BL_P00:  blend_pix = pix_r[0];
      BL_P10:  blend_pix = pix_r[1];
      BL_P01:  blend_pix = pix_r[2];
      default: blend_pix = pix_r[3];
    endcase
    case (ch_r)
      CH_RED:   byte_sel = blend_pix[23:16];
      CH_GREEN: byte_sel = blend_pix[15:8];
      default:  byte_sel = blend_pix[7:0];
    endcase
    fx_inv = ONE - {1'b0, frac_r[0]};
    fy_inv = ONE - {1'b0, frac_r[1]};
  end

  // Store ports.
  always_comb begin
    src_we   = (state_r == S_LOAD_WR) && (kind_r == KIND_RGB) && load_ok;
    alp_we   = (state_r == S_LOAD_WR) && (kind_r == KIND_ALPHA) && load_ok;
    src_re   = (state_r == S_RD_ADDR) && (rd_n_r != RD_ALPHA) && src_inb;
    alp_re   = (state_r == S_RD_ADDR) && (rd_n_r == RD_ALPHA) && alp_inb;
    src_addr = (state_r == S_LOAD_WR) ? SRC_AW'(pix_idx_r) : SRC_AW'(idx);
    alp_addr = (state_r == S_LOAD_WR) ? ALP_AW'(pix_idx_r) : ALP_AW'(idx);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ax_sel_nxt    = ax_sel_r;
    rd_n_nxt      = rd_n_r;
    st_nxt        = st_r;
    ch_nxt        = ch_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    pix_idx_nxt   = pix_idx_r;
    rgb_in_nxt    = rgb_in_r;
    alpha_in_nxt  = alpha_in_r;
    alpha_nxt     = alpha_r;
    oob_nxt       = oob_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    out_alpha_nxt = out_alpha_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    for (int k = 0; k < NUM_REGS; k++) begin
      regs_nxt[k] = regs_r[k];
    end
    for (int k = 0; k < 2; k++) begin
      neg_nxt[k]    = neg_r[k];
      iq_nxt[k]     = iq_r[k];
      frac_nxt[k]   = frac_r[k];
      acoord_nxt[k] = acoord_r[k];
    end
    for (int k = 0; k < 4; k++) begin
      pix_nxt[k] = pix_r[k];
    end
    for (int k = 0; k < 3; k++) begin
      chan_nxt[k] = chan_r[k];
    end

    mac_cmd.valid = 1'b0;
    mac_cmd.accum = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    mac_addend    = '0;
    div_start     = 1'b0;
    div_dividend  = '0;

    // The output register frees once its transfer completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_kind;
          pix_idx_nxt  = in_pixel_index;
          rgb_in_nxt   = {in_red, in_green, in_blue};
          alpha_in_nxt = in_alpha;
          if (in_kind == KIND_RGB || in_kind == KIND_ALPHA) begin
            state_nxt = S_LOAD_MUL;
          end else if (in_kind == KIND_EMIT) begin
            ax_sel_nxt = 1'b0;
            state_nxt  = S_MAP_MUL;
          end
        end
      end
      S_LOAD_MUL: begin
        mac_cmd.valid = 1'b1;
        mac_a         = MA_W'((kind_r == KIND_RGB) ? sw : aw);
        mac_b         = MB_W'((kind_r == KIND_RGB) ? sh : ah);
        state_nxt     = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        state_nxt = S_IDLE;
      end
      S_MAP_MUL: begin
        mac_cmd.valid = 1'b1;
        mac_a         = MA_W'(odd);
        mac_b         = MB_W'(src_sel);
        state_nxt     = S_MAP_CHK;
      end
      S_MAP_CHK: begin
        // A numerator below zero has integer part minus one.
        div_start = 1'b1;
        if (prod < dst_ext) begin
          neg_nxt[ax_sel_r] = 1'b1;
          iq_nxt[ax_sel_r]  = '0;
          div_dividend      = DVD_W'(prod + dst_ext) << F;
          state_nxt         = S_FDIV;
        end else begin
          neg_nxt[ax_sel_r] = 1'b0;
          div_dividend      = DVD_W'(prod - dst_ext);
          state_nxt         = S_IDIV;
        end
      end
      S_IDIV: begin
        if (div_stat.done) begin
          iq_nxt[ax_sel_r] = DIM_W'(div_quo);
          div_start        = 1'b1;
          div_dividend     = DVD_W'(div_rem) << F;
          state_nxt        = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          frac_nxt[ax_sel_r] = div_quo[F-1:0];
          state_nxt          = S_AMUL;
        end
      end
      S_AMUL: begin
        mac_cmd.valid = 1'b1;
        mac_a         = MA_W'(odd);
        mac_b         = MB_W'(asz_sel);
        state_nxt     = S_ASTART;
      end
      S_ASTART: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(prod);
        state_nxt    = S_ADIV;
      end
      S_ADIV: begin
        if (div_stat.done) begin
          if (div_quo > DVD_W'(asz_sel - DIM_W'(1))) begin
            acoord_nxt[ax_sel_r] = asz_sel - DIM_W'(1);
          end else begin
            acoord_nxt[ax_sel_r] = DIM_W'(div_quo);
          end
          if (!ax_sel_r) begin
            ax_sel_nxt = 1'b1;
            state_nxt  = S_MAP_MUL;
          end else begin
            rd_n_nxt  = RD_P00;
            state_nxt = S_RD_MUL;
          end
        end
      end
      S_RD_MUL: begin
        mac_cmd.valid = 1'b1;
        mac_a         = MA_W'(rd_y);
        mac_b         = MB_W'(rd_w);
        mac_addend    = ACC_W'(rd_x);
        state_nxt     = S_RD_ADDR;
      end
      S_RD_ADDR: begin
        oob_nxt   = (rd_n_r == RD_ALPHA) ? !alp_inb : !src_inb;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (rd_n_r == RD_ALPHA) begin
          alpha_nxt = oob_r ? '0 : alp_rdata;
          st_nxt    = BL_P00;
          ch_nxt    = CH_RED;
          state_nxt = S_BLEND;
        end else begin
          pix_nxt[rd_n_r[1:0]] = oob_r ? '0 : src_rdata;
          rd_n_nxt             = rd_n_r + 3'd1;
          state_nxt            = S_RD_MUL;
        end
      end
      S_BLEND: begin
        // Blend along x for each source row, then along y, then round.
        st_nxt = st_r + 3'd1;
        case (st_r)
          BL_P00: begin
            mac_cmd.valid = 1'b1;
            mac_a         = MA_W'(byte_sel);
            mac_b         = MB_W'(fx_inv);
          end
          BL_P10: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.accum = 1'b1;
            mac_a         = MA_W'(byte_sel);
            mac_b         = MB_W'(frac_r[0]);
          end
          BL_P01: begin
            h0_nxt        = mac_acc[MA_W-1:0];
            mac_cmd.valid = 1'b1;
            mac_a         = MA_W'(byte_sel);
            mac_b         = MB_W'(fx_inv);
          end
          BL_P11: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.accum = 1'b1;
            mac_a         = MA_W'(byte_sel);
            mac_b         = MB_W'(frac_r[0]);
          end
          BL_ROW0: begin
            h1_nxt        = mac_acc[MA_W-1:0];
            mac_cmd.valid = 1'b1;
            mac_a         = h0_r;
            mac_b         = MB_W'(fy_inv);
            mac_addend    = ROUND;
          end
          BL_ROW1: begin
            mac_cmd.valid = 1'b1;
            mac_cmd.accum = 1'b1;
            mac_a         = h1_r;
            mac_b         = MB_W'(frac_r[1]);
          end
          default: begin
            chan_nxt[ch_r] = mac_acc[2 * F +: BYTE_W];
            st_nxt         = BL_P00;
            if (ch_r == CH_BLUE) begin
              state_nxt = S_IDX_MUL;
            end else begin
              ch_nxt = ch_r + 2'd1;
            end
          end
        endcase
      end
      S_IDX_MUL: begin
        mac_cmd.valid = 1'b1;
        mac_a         = MA_W'(row_r);
        mac_b         = MB_W'(dw);
        mac_addend    = ACC_W'(col_r);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_alpha_nxt = alpha_r;
          out_red_nxt   = chan_r[0];
          out_green_nxt = chan_r[1];
          out_blue_nxt  = chan_r[2];
          out_index_nxt = mac_acc[DIDX_W-1:0];
          out_last_nxt  = (col_r == dw - DIM_W'(1)) && (row_r == dh - DIM_W'(1));
          // Advance the raster position, wrapping at the frame end.
          if (col_r + DIM_W'(1) >= dw) begin
            col_nxt = '0;
            if (row_r + DIM_W'(1) >= dh) begin
              row_nxt = '0;
            end else begin
              row_nxt = row_r + DIM_W'(1);
            end
          end else begin
            col_nxt = col_r + DIM_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write restarts the destination frame.
    if (cfg_valid && cfg_index <= REG_ALPHA_H) begin
      regs_nxt[cfg_index] = cfg_data;
      col_nxt             = '0;
      row_nxt             = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_sel_r    <= 1'b0;
      rd_n_r      <= RD_P00;
      st_r        <= BL_P00;
      ch_r        <= CH_RED;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_REGS; k++) begin
        regs_r[k] <= DIM_W'(1);
      end
    end else begin
      state_r     <= state_nxt;
      ax_sel_r    <= ax_sel_nxt;
      rd_n_r      <= rd_n_nxt;
      st_r        <= st_nxt;
      ch_r        <= ch_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < NUM_REGS; k++) begin
        regs_r[k] <= regs_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    pix_idx_r   <= pix_idx_nxt;
    rgb_in_r    <= rgb_in_nxt;
    alpha_in_r  <= alpha_in_nxt;
    alpha_r     <= alpha_nxt;
    oob_r       <= oob_nxt;
    h0_r        <= h0_nxt;
    h1_r        <= h1_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
    for (int k = 0; k < 2; k++) begin
      neg_r[k]    <= neg_nxt[k];
      iq_r[k]     <= iq_nxt[k];
      frac_r[k]   <= frac_nxt[k];
      acoord_r[k] <= acoord_nxt[k];
    end
    for (int k = 0; k < 4; k++) begin
      pix_r[k] <= pix_nxt[k];
    end
    for (int k = 0; k < 3; k++) begin
      chan_r[k] <= chan_nxt[k];
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_alpha      = out_alpha_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_dest_index = out_index_r;
  assign out_last       = out_last_r;

  // A request keeps the block busy for at least the next cycle.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_EMIT) |=> !in_ready)
    else $error("input ready right after a pixel request");

  // A result appears only from the output step of the sequencer.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output valid raised outside the output step");

  // The divider is never restarted while a division is still running.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/bilr_ram.sv =====
`default_nettype none

module bilr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bilr_mac.sv =====
`default_nettype none

module bilr_mac import bilr_pkg::*; #(
  parameter int A_W   = 24,
  parameter int B_W   = 17,
  parameter int ACC_W = 42
) (
  input  wire logic             clk,
  input  wire mac_cmd_t         cmd,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  input  wire logic [ACC_W-1:0] addend,
  output      logic [ACC_W-1:0] acc
);

  logic [A_W+B_W-1:0] prod;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;

  // One product per cycle, added to the running sum or to a fresh addend.
  always_comb begin
    prod    = a * b;
    acc_nxt = (cmd.accum ? acc_r : addend) + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bilr_div.sv =====
`default_nettype none

module bilr_div import bilr_pkg::*; #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output      div_stat_t        stat,
  output      logic [DVD_W-1:0] quotient,
  output      logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted  = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[DVS_W-1:0];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
  import bilr_pkg::*;

  // Kind code that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [DIDX_W-1:0] dest_index;
    logic last;
  } argb_pixel_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0] pix;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    bit typed;
    argb_pixel_t pixel;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [KIND_W-1:0] in_kind;
  logic [PIX_W-1:0] in_pixel_index;
  logic [BYTE_W-1:0] in_red;
  logic [BYTE_W-1:0] in_green;
  logic [BYTE_W-1:0] in_blue;
  logic [BYTE_W-1:0] in_alpha;
  logic out_valid;
  logic out_ready;
  logic [BYTE_W-1:0] out_alpha;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;
  logic [DIDX_W-1:0] out_dest_index;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  // Shadow of the block: size registers, raster position and loaded pixels.
  logic [DIM_W-1:0] size_regs [NUM_REGS];
  int unsigned next_col;
  int unsigned next_row;
  logic [RGB_W-1:0] rgb_image [int unsigned];
  logic [BYTE_W-1:0] alpha_image [int unsigned];

  argb_pixel_t pending_pixels [$];
  int errors;
  int pixels_seen;
  bit calm;
  int idle_cycles;

  bilinear_rgb_resampler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_pixel_index(in_pixel_index), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_ready(out_ready), .out_alpha(out_alpha),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_dest_index(out_dest_index), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A size of zero acts as one, and large sizes saturate.
  function automatic longint unsigned size_of(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > MAX_DIMENSION_DEF) begin
      return MAX_DIMENSION_DEF;
    end
    return longint'(v);
  endfunction

  // Half-pixel-center mapping of one destination coordinate onto a source axis.
  function automatic void map_axis(input longint unsigned d, input longint unsigned src,
                                   input longint unsigned dst, output longint ipart,
                                   output longint unsigned frac);
    longint num;
    longint den;
    longint rem;
    num = longint'((2 * d + 1) * src) - longint'(dst);
    den = 2 * longint'(dst);
    if (num < 0) begin
      ipart = -1;
      rem = num + den;
    end else begin
      ipart = num / den;
      rem = num - ipart * den;
    end
    frac = (longint'(rem) << FRACTION_BITS_DEF) / den;
  endfunction

  function automatic longint unsigned clamp_to(input longint v, input longint unsigned n);
    if (v < 0) begin
      return 0;
    end
    if (v > longint'(n) - 1) begin
      return n - 1;
    end
    return v;
  endfunction

  // Raster indexes of the four source neighbours and of the alpha sample
  // that the pixel at the current raster position reads.
  function automatic void sample_points(output longint unsigned taps [4],
                                        output longint unsigned alpha_at,
                                        output longint unsigned frac_x,
                                        output longint unsigned frac_y);
    longint unsigned sw, sh, dw, dh, aw, ah, ax, ay;
    longint ix, iy;
    sw = size_of(size_regs[REG_SRC_W]);
    sh = size_of(size_regs[REG_SRC_H]);
    dw = size_of(size_regs[REG_DST_W]);
    dh = size_of(size_regs[REG_DST_H]);
    aw = size_of(size_regs[REG_ALPHA_W]);
    ah = size_of(size_regs[REG_ALPHA_H]);
    map_axis(next_col, sw, dw, ix, frac_x);
    map_axis(next_row, sh, dh, iy, frac_y);
    taps[0] = clamp_to(iy, sh) * sw + clamp_to(ix, sw);
    taps[1] = clamp_to(iy, sh) * sw + clamp_to(ix + 1, sw);
    taps[2] = clamp_to(iy + 1, sh) * sw + clamp_to(ix, sw);
    taps[3] = clamp_to(iy + 1, sh) * sw + clamp_to(ix + 1, sw);
    ax = ((2 * longint'(next_col) + 1) * aw) / (2 * dw);
    ay = ((2 * longint'(next_row) + 1) * ah) / (2 * dh);
    if (ax > aw - 1) begin
      ax = aw - 1;
    end
    if (ay > ah - 1) begin
      ay = ah - 1;
    end
    alpha_at = ay * aw + ax;
  endfunction

  // Applies one accepted item to the shadow and yields the pixel it causes.
  function automatic bit resample_item(input logic [KIND_W-1:0] kind,
                                       input logic [PIX_W-1:0] pix,
                                       input logic [BYTE_W-1:0] r,
                                       input logic [BYTE_W-1:0] g,
                                       input logic [BYTE_W-1:0] b,
                                       input logic [BYTE_W-1:0] a,
                                       output argb_pixel_t px);
    longint unsigned taps [4];
    longint unsigned alpha_at, fx, fy, one, dw, dh;
    longint unsigned weight [4];
    longint unsigned acc [3];
    logic [RGB_W-1:0] rgb;
    px = '{default: '0};
    if (kind == KIND_RGB) begin
      if (pix < size_of(size_regs[REG_SRC_W]) * size_of(size_regs[REG_SRC_H]) &&
          pix < SOURCE_PIXELS_DEF) begin
        rgb_image[pix] = {r, g, b};
      end
      return 1'b0;
    end
    if (kind == KIND_ALPHA) begin
      if (pix < size_of(size_regs[REG_ALPHA_W]) * size_of(size_regs[REG_ALPHA_H]) &&
          pix < ALPHA_PIXELS_DEF) begin
        alpha_image[pix] = a;
      end
      return 1'b0;
    end
    if (kind != KIND_EMIT) begin
      return 1'b0;
    end
    sample_points(taps, alpha_at, fx, fy);
    one = 64'd1 << FRACTION_BITS_DEF;
    weight[0] = (one - fx) * (one - fy);
    weight[1] = fx * (one - fy);
    weight[2] = (one - fx) * fy;
    weight[3] = fx * fy;
    for (int c = 0; c < 3; c++) begin
      acc[c] = 64'd1 << (2 * FRACTION_BITS_DEF - 1);
      for (int n = 0; n < 4; n++) begin
        rgb = (taps[n] < SOURCE_PIXELS_DEF && rgb_image.exists(taps[n])) ?
              rgb_image[taps[n]] : '0;
        acc[c] += longint'((rgb >> (16 - 8 * c)) & 8'hff) * weight[n];
      end
      acc[c] = acc[c] >> (2 * FRACTION_BITS_DEF);
    end
    dw = size_of(size_regs[REG_DST_W]);
    dh = size_of(size_regs[REG_DST_H]);
    px.alpha = (alpha_at < ALPHA_PIXELS_DEF && alpha_image.exists(alpha_at)) ?
               alpha_image[alpha_at] : '0;
    px.red = acc[0][7:0];
    px.green = acc[1][7:0];
    px.blue = acc[2][7:0];
    px.dest_index = DIDX_W'(next_row * dw + next_col);
    px.last = (next_col == dw - 1 && next_row == dh - 1);
    next_col++;
    if (next_col >= dw) begin
      next_col = 0;
      next_row++;
      if (next_row >= dh) begin
        next_row = 0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    errors++;
  endtask

  // Offers one item; after its transfer the shadow is updated.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] pix,
                           input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                           input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] a,
                           input bit typed, input argb_pixel_t typed_px);
    argb_pixel_t px;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_kind = kind;
    in_pixel_index = pix;
    in_red = r;
    in_green = g;
    in_blue = b;
    in_alpha = a;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (resample_item(kind, pix, r, g, b, a, px)) begin
      pending_pixels.push_back(typed ? typed_px : px);
    end
  endtask

  // Loads every neighbour and the alpha sample that the next pixel reads and
  // that were never loaded, then requests the pixel.
  task automatic request_pixel();
    longint unsigned taps [4];
    longint unsigned alpha_at, fx, fy;
    argb_pixel_t none;
    none = '{default: '0};
    sample_points(taps, alpha_at, fx, fy);
    for (int n = 0; n < 4; n++) begin
      if (taps[n] < SOURCE_PIXELS_DEF && !rgb_image.exists(taps[n])) begin
        send_item(KIND_RGB, PIX_W'(taps[n]), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, none);
      end
    end
    if (alpha_at < ALPHA_PIXELS_DEF && !alpha_image.exists(alpha_at)) begin
      send_item(KIND_ALPHA, PIX_W'(alpha_at), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'b0, none);
    end
    send_item(KIND_EMIT, PIX_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 1'b0, none);
  endtask

  // Waits until the block is idle, then writes all six size registers.
  task automatic write_sizes(input logic [DIM_W-1:0] sizes [NUM_REGS]);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k < NUM_REGS; k++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = CFG_IDX_W'(k);
      cfg_data = sizes[k];
      do @(posedge clk); while (!cfg_ready);
      size_regs[k] = sizes[k];
      next_col = 0;
      next_row = 0;
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  // Random traffic for one size setting.
  task automatic random_phase(input int items);
    longint unsigned src_n, alpha_n;
    int pick;
    argb_pixel_t none;
    none = '{default: '0};
    src_n = size_of(size_regs[REG_SRC_W]) * size_of(size_regs[REG_SRC_H]);
    alpha_n = size_of(size_regs[REG_ALPHA_W]) * size_of(size_regs[REG_ALPHA_H]);
    if (src_n > SOURCE_PIXELS_DEF) begin
      src_n = SOURCE_PIXELS_DEF;
    end
    if (alpha_n > ALPHA_PIXELS_DEF) begin
      alpha_n = ALPHA_PIXELS_DEF;
    end
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        request_pixel();
      end else if (pick < 65) begin
        send_item(KIND_RGB, PIX_W'($urandom_range(0, int'(src_n - 1))), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none);
      end else if (pick < 85) begin
        send_item(KIND_ALPHA, PIX_W'($urandom_range(0, int'(alpha_n - 1))), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none);
      end else if (pick < 94) begin
        send_item(pick[0] ? KIND_RGB : KIND_ALPHA, PIX_W'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none);
      end else begin
        send_item(KIND_NONE, PIX_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, none);
      end
    end
  endtask

  // Result side: random stalls and one long hold-off once traffic is flowing.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (!held && pixels_seen >= 30) begin
        held = 1'b1;
        hold = 2000;
        out_ready = 1'b0;
      end else begin
        out_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Compare every transferred pixel with the oldest expectation.
  always @(posedge clk) begin
    argb_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, dest_index", out_dest_index, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_alpha !== want.alpha) report_mismatch("alpha", out_alpha, want.alpha);
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_dest_index !== want.dest_index) begin
          report_mismatch("dest_index", out_dest_index, want.dest_index);
        end
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("bilinear_rgb_resampler regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: directed table at reset sizes, then random phases.
  initial begin
    directed_row_t directed [$];
    logic [DIM_W-1:0] phases [8][NUM_REGS];
    int phase_items [8];
    errors = 0;
    pixels_seen = 0;
    idle_cycles = 0;
    calm = 1'b0;
    next_col = 0;
    next_row = 0;
    for (int k = 0; k < NUM_REGS; k++) size_regs[k] = DIM_W'(1);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_RGB;
    in_pixel_index = '0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_alpha = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SRC_W;
    cfg_data = '0;

    directed.push_back('{KIND_RGB, 0, 10, 20, 30, 0, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_ALPHA, 0, 0, 0, 0, 40, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_EMIT, 0, 0, 0, 0, 0, 1, '{40, 10, 20, 30, 0, 1}});
    // Loads outside the 1x1 image and an unknown kind leave the pixel alone.
    directed.push_back('{KIND_RGB, 1, 255, 255, 255, 255, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_ALPHA, 1, 255, 255, 255, 255, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_RGB, 20'hfffff, 1, 1, 1, 1, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_NONE, 0, 99, 99, 99, 99, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_EMIT, 20'hfffff, 0, 0, 0, 0, 1, '{40, 10, 20, 30, 0, 1}});
    directed.push_back('{KIND_RGB, 0, 255, 255, 255, 0, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_ALPHA, 0, 0, 0, 0, 255, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_EMIT, 0, 0, 0, 0, 0, 1, '{255, 255, 255, 255, 0, 1}});
    directed.push_back('{KIND_RGB, 0, 0, 0, 0, 255, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_ALPHA, 0, 255, 255, 255, 0, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_EMIT, 0, 255, 255, 255, 255, 1, '{0, 0, 0, 0, 0, 1}});
    directed.push_back('{KIND_RGB, 0, 8'h55, 8'haa, 8'h0f, 0, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_ALPHA, 0, 0, 0, 0, 8'ha5, 0, '{0, 0, 0, 0, 0, 0}});
    directed.push_back('{KIND_EMIT, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});

    // Size settings: mixed scaling, zero sizes, saturation and the maximum.
    phases[0] = '{3, 2, 5, 4, 2, 3};
    phases[1] = '{0, 0, 0, 0, 0, 0};
    phases[2] = '{8191, 1, 3, 1, 8191, 1};
    phases[3] = '{4096, 4096, 2, 2, 4096, 4096};
    phases[4] = '{7, 5, 3, 9, 4, 4};
    phases[5] = '{1, 1, 4096, 1, 1, 4096};
    phases[6] = '{16, 12, 16, 12, 16, 12};
    phases[7] = '{2, 2, 7, 7, 1, 1};
    phase_items = '{200, 100, 160, 120, 180, 120, 100, 160};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i].kind, directed[i].pix, directed[i].red, directed[i].green,
                directed[i].blue, directed[i].alpha, directed[i].typed,
                directed[i].pixel);
    end

    for (int p = 0; p < 8; p++) begin
      write_sizes(phases[p]);
      // The last setting runs without any idling on either side.
      calm = (p == 7);
      random_phase(phase_items[p]);
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bilinear_rgb_resampler regression: pass");
    end else begin
      $display("bilinear_rgb_resampler regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/bilr_pkg.sv
hw/rtl/bilr_ram.sv
hw/rtl/bilr_mac.sv
hw/rtl/bilr_div.sv
hw/rtl/bilinear_rgb_resampler.sv
bench/tb_top.sv
